### sv/cowm_pkg.sv
// Types and constants shared by the copy-on-write overlay block state map.
// No dependencies; every module of the block but cowm_ram imports this package.
`default_nettype none

package cowm_pkg;

   localparam int POS_W       = 17;
   localparam int IDX_W       = 16;
   localparam int CNT_W       = 6;
   localparam int BYTES_W     = 22;
   localparam int DEV_W       = 33;
   localparam int SHIFT_W     = 5;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 72;
   localparam int MAX_RUN     = 32;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd9;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_CACHE  = 3'd1;
   localparam logic [2:0] CMD_WRITE  = 3'd2;
   localparam logic [2:0] CMD_TRIM   = 3'd3;
   localparam logic [2:0] CMD_STATUS = 3'd4;

   localparam logic [1:0] CM_IGNORE = 2'd0;
   localparam logic [1:0] CM_PASS   = 2'd1;
   localparam logic [1:0] CM_RDONLY = 2'd2;
   localparam logic [1:0] CM_COPY   = 2'd3;

   localparam logic [1:0] BS_FREE  = 2'd0;
   localparam logic [1:0] BS_ALLOC = 2'd1;
   localparam logic [1:0] BS_TRIM  = 2'd3;

   localparam logic CSR_BLOCK_SHIFT  = 1'b0;
   localparam logic CSR_DEVICE_BYTES = 1'b1;

   typedef enum logic [2:0] {
      ACT_RD_UNDER = 3'd0,
      ACT_RD_OVER  = 3'd1,
      ACT_ZERO     = 3'd2,
      ACT_NONE     = 3'd3,
      ACT_ADVISE   = 3'd4,
      ACT_FWD      = 3'd5,
      ACT_WRITE    = 3'd6
   } action_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [IDX_W-1:0] block_index;
      logic [CNT_W-1:0] block_count;
      logic             copy_on_read;
      logic [1:0]       cache_mode;
   } req_type;

   // One result before byte counts: clip selects device-end clipping,
   // full selects the whole run length.
   typedef struct packed {
      action_type       action;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] run;
      logic             clip;
      logic             full;
      logic             copy;
      logic             present;
      logic             trimmed;
      logic             last;
   } run_desc_type;

endpackage

`default_nettype wire

### sv/cowm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cowm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/cowm_seq.sv
// Command sequencer: clears the state memory, scans block states, splits reads
// into runs and writes back new states. Uses cowm_pkg; drives the cowm_ram ports.
`default_nettype none

module cowm_seq
   import cowm_pkg::*;
#(
   parameter int NUM_BLOCKS = 65536,
   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire req_type       req,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [1:0]         ram_wdata,
   output logic [AW-1:0]      ram_raddr,
   input  wire logic [1:0]    ram_rdata,
   output run_desc_type       desc,
   output logic               desc_valid,
   input  wire logic          desc_take
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_ONE   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_FLUSH = 5'b10000
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic             cor_ff, cor_in;
   logic [1:0]       mode_ff, mode_in;
   logic [POS_W-1:0] run_pos_ff, run_pos_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [1:0]       run_st_ff, run_st_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             rd_inmap_ff, rd_inmap_in;
   logic [AW-1:0]    clr_ff, clr_in;
   run_desc_type     desc_ff, desc_in;
   logic             desc_vld_ff, desc_vld_in;

   logic [POS_W-1:0]    cur;
   logic [POS_W-1:0]    rpos;
   logic [AW+POS_W-1:0] cur_ext;
   logic [AW+POS_W-1:0] rpos_ext;
   logic                cur_inmap;
   logic [1:0]          s;
   logic                desc_free;
   logic                desc_load;
   logic                accept;
   logic [CNT_W-1:0]    cnt_eff;
   logic [CNT_W-1:0]    len_next;
   logic [CNT_W-1:0]    rem_next;

   function automatic run_desc_type read_run(logic [POS_W-1:0] pos, logic [CNT_W-1:0] len,
                                             logic [1:0] st, logic cor, logic last);
      run_desc_type d;
      d        = '0;
      d.pos    = pos;
      d.run    = len;
      d.last   = last;
      case (st)
         BS_FREE: begin
            d.action = ACT_RD_UNDER;
            d.clip   = 1'b1;
            d.copy   = cor;
         end
         BS_ALLOC: begin
            d.action = ACT_RD_OVER;
            d.full   = 1'b1;
         end
         default: begin
            d.action = ACT_ZERO;
            d.full   = 1'b1;
         end
      endcase
      return d;
   endfunction

   assign cur       = run_pos_ff + {{(POS_W-CNT_W){1'b0}}, run_len_ff};
   assign cur_ext   = {{AW{1'b0}}, cur};
   assign cur_inmap = ({{(32-POS_W){1'b0}}, cur} < 32'(NUM_BLOCKS));
   assign rpos_ext  = {{AW{1'b0}}, rpos};
   assign ram_raddr = rpos_ext[AW-1:0];
   assign s         = rd_inmap_ff ? ram_rdata : BS_FREE;
   assign desc_free = !desc_vld_ff || desc_take;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign len_next  = run_len_ff + 6'd1;
   assign rem_next  = rem_ff - run_len_ff;

   always_comb begin
      if (req.block_count == '0) begin
         cnt_eff = 6'd1;
      end else if ({1'b0, req.block_count} > 7'(MAX_RUN)) begin
         cnt_eff = CNT_W'(MAX_RUN);
      end else begin
         cnt_eff = req.block_count;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      cor_in     = cor_ff;
      mode_in    = mode_ff;
      run_pos_in = run_pos_ff;
      run_len_in = run_len_ff;
      run_st_in  = run_st_ff;
      rem_in     = rem_ff;
      clr_in     = clr_ff;
      desc_in    = desc_ff;
      desc_load  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = cur_ext[AW-1:0];
      ram_wdata  = BS_ALLOC;
      rpos       = cur;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = BS_FREE;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rpos = {1'b0, req.block_index};
            if (accept) begin
               cmd_in     = req.cmd;
               cor_in     = req.copy_on_read;
               mode_in    = req.cache_mode;
               run_pos_in = {1'b0, req.block_index};
               run_len_in = '0;
               run_st_in  = BS_FREE;
               rem_in     = cnt_eff;
               state_in   = (req.cmd == CMD_READ) ? S_SCAN : S_ONE;
            end
         end
         S_ONE: begin
            if (desc_free) begin
               desc_load      = 1'b1;
               desc_in        = '0;
               desc_in.pos    = run_pos_ff;
               desc_in.run    = 6'd1;
               desc_in.last   = 1'b1;
               desc_in.action = ACT_NONE;
               state_in       = S_IDLE;
               unique case (cmd_ff)
                  CMD_CACHE: begin
                     if (s == BS_ALLOC) begin
                        desc_in.action = ACT_ADVISE;
                        desc_in.full   = 1'b1;
                     end else if (s == BS_FREE && mode_ff != CM_IGNORE) begin
                        desc_in.clip = 1'b1;
                        case (mode_ff)
                           CM_PASS:   desc_in.action = ACT_FWD;
                           CM_RDONLY: desc_in.action = ACT_RD_UNDER;
                           default: begin
                              desc_in.action = ACT_RD_UNDER;
                              desc_in.copy   = 1'b1;
                              ram_we         = cur_inmap;
                           end
                        endcase
                     end
                  end
                  CMD_WRITE: begin
                     desc_in.action = ACT_WRITE;
                     desc_in.full   = 1'b1;
                     ram_we         = cur_inmap;
                  end
                  CMD_TRIM: begin
                     ram_we    = cur_inmap;
                     ram_wdata = BS_TRIM;
                  end
                  CMD_STATUS: begin
                     desc_in.present = (s != BS_FREE);
                     desc_in.trimmed = (s == BS_TRIM);
                  end
                  default: begin
                     desc_in        = '0;
                     desc_in.action = ACT_NONE;
                     desc_in.last   = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (desc_free) begin
               rpos   = cur + 17'd1;
               ram_we = (s == BS_FREE) && cor_ff && cur_inmap;
               if (run_len_ff == '0 || s == run_st_ff) begin
                  run_len_in = len_next;
                  run_st_in  = s;
                  if (len_next == rem_ff) begin
                     desc_load = 1'b1;
                     desc_in   = read_run(run_pos_ff, len_next, s, cor_ff, 1'b1);
                     state_in  = S_IDLE;
                  end
               end else begin
                  desc_load  = 1'b1;
                  desc_in    = read_run(run_pos_ff, run_len_ff, run_st_ff, cor_ff, 1'b0);
                  run_pos_in = cur;
                  run_len_in = 6'd1;
                  run_st_in  = s;
                  rem_in     = rem_next;
                  if (rem_next == 6'd1) begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (desc_free) begin
               desc_load = 1'b1;
               desc_in   = read_run(run_pos_ff, run_len_ff, run_st_ff, cor_ff, 1'b1);
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_inmap_in = ({{(32-POS_W){1'b0}}, rpos} < 32'(NUM_BLOCKS));
   assign desc_vld_in = desc_load || (desc_vld_ff && !desc_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         desc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         desc_vld_ff <= desc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cor_ff      <= cor_in;
      mode_ff     <= mode_in;
      run_pos_ff  <= run_pos_in;
      run_len_ff  <= run_len_in;
      run_st_ff   <= run_st_in;
      rem_ff      <= rem_in;
      rd_inmap_ff <= rd_inmap_in;
      desc_ff     <= desc_in;
   end

   assign desc       = desc_ff;
   assign desc_valid = desc_vld_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FLUSH) |-> !ram_we)
      else $error("state memory written outside a command");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      desc_load |-> desc_free)
      else $error("run descriptor overwritten before taken");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> run_len_ff < rem_ff)
      else $error("run length reached remaining count inside scan");

   a_scan_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && ram_we) |-> (ram_wdata == BS_ALLOC && s == BS_FREE))
      else $error("scan wrote a block that was not free");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && state_in == S_IDLE) |-> clr_ff == AW'(NUM_BLOCKS - 1))
      else $error("clearing pass ended early");

endmodule

`default_nettype wire

### sv/cowm_bytes.sv
// Byte count stage: turns a run descriptor into valid and tail byte counts, clipped
// at the device end where the descriptor asks, and holds the result register. Uses cowm_pkg.
`default_nettype none

module cowm_bytes
   import cowm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire run_desc_type           desc,
   input  wire logic                   desc_valid,
   output logic                        desc_take,
   input  wire logic [SHIFT_W-1:0]     shift,
   input  wire logic [DEV_W-1:0]       device_bytes,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic [2:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   logic               out_vld_ff, out_vld_in;
   logic [2:0]         action_ff;
   logic [IDX_W-1:0]   first_ff;
   logic [CNT_W-1:0]   run_ff;
   logic [BYTES_W-1:0] valid_ff, valid_in;
   logic [BYTES_W-1:0] tail_ff, tail_in;
   logic               copy_ff, present_ff, trimmed_ff, last_ff;

   logic [DEV_W-1:0]   offset;
   logic [BYTES_W-1:0] nbytes;
   logic [DEV_W-1:0]   avail;
   logic [BYTES_W-1:0] lim;

   assign desc_take  = desc_valid && (!out_vld_ff || rsp_tready);
   assign out_vld_in = desc_take || (out_vld_ff && !rsp_tready);

   assign offset = {{(DEV_W-POS_W){1'b0}}, desc.pos} << shift;
   assign nbytes = {{(BYTES_W-CNT_W){1'b0}}, desc.run} << shift;
   assign avail  = device_bytes - offset;

   always_comb begin
      if (device_bytes <= offset) begin
         lim = '0;
      end else if (avail > {{(DEV_W-BYTES_W){1'b0}}, nbytes}) begin
         lim = nbytes;
      end else begin
         lim = avail[BYTES_W-1:0];
      end
      if (desc.clip) begin
         valid_in = lim;
         tail_in  = nbytes - lim;
      end else begin
         valid_in = desc.full ? nbytes : '0;
         tail_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_take) begin
         action_ff  <= desc.action;
         first_ff   <= desc.pos[IDX_W-1:0];
         run_ff     <= desc.run;
         valid_ff   <= valid_in;
         tail_ff    <= tail_in;
         copy_ff    <= desc.copy;
         present_ff <= desc.present;
         trimmed_ff <= desc.trimmed;
         last_ff    <= desc.last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = action_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {3'b000, trimmed_ff, present_ff, copy_ff, tail_ff, valid_ff,
                        run_ff, first_ff};

endmodule

`default_nettype wire

### sv/cow_overlay_block_state_map_top.sv
// Top level of the copy-on-write overlay block state map: configuration
// registers and wiring. Uses cowm_pkg, cowm_ram, cowm_seq and cowm_bytes.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: index, count, copy, mode; tuser: cmd
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: block, run, bytes, flags; tuser: action
//   csr_     in   csr_valid/csr_ready    csr_addr register index, csr_wdata value
//
// Single-block commands pass through the S_ONE state of the sequencer; a read scans
// its blocks in S_SCAN, and S_FLUSH sends a final single-block run after a state change.
// The state memory port gives one block state per cycle; it sets the scan rate.
// After reset a clearing pass writes NUM_BLOCKS entries, one per cycle, before
// the first request is taken. A stalled result stage holds the scan in place.
`default_nettype none

module cow_overlay_block_state_map_top
   import cowm_pkg::*;
#(
   parameter int NUM_BLOCKS = 65536
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] block_index, [21:16] block_count, [22] copy_on_read, [24:23] cache_mode
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] cmd
   input  wire logic [2:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] first_block, [21:16] run_blocks, [43:22] valid_bytes,
   // [65:44] tail_bytes, [66] copy_to_overlay, [67] present, [68] trimmed
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [2:0] action
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_addr,
   input  wire logic [DEV_W-1:0]      csr_wdata
);

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   logic [SHIFT_W-1:0] block_shift_ff, block_shift_in;
   logic [DEV_W-1:0]   device_bytes_ff, device_bytes_in;
   logic [SHIFT_W-1:0] eff_shift;

   req_type            req;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [1:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [1:0]         ram_rdata;
   run_desc_type       desc;
   logic               desc_valid;
   logic               desc_take;

   assign csr_ready = 1'b1;

   always_comb begin
      block_shift_in  = block_shift_ff;
      device_bytes_in = device_bytes_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_BLOCK_SHIFT:  block_shift_in  = csr_wdata[SHIFT_W-1:0];
            CSR_DEVICE_BYTES: device_bytes_in = csr_wdata;
            default:          block_shift_in  = block_shift_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff  <= SHIFT_RESET;
         device_bytes_ff <= '0;
      end else begin
         block_shift_ff  <= block_shift_in;
         device_bytes_ff <= device_bytes_in;
      end
   end

   always_comb begin
      if (block_shift_ff < SHIFT_MIN) begin
         eff_shift = SHIFT_MIN;
      end else if (block_shift_ff > SHIFT_MAX) begin
         eff_shift = SHIFT_MAX;
      end else begin
         eff_shift = block_shift_ff;
      end
   end

   assign req.cmd          = req_tuser;
   assign req.block_index  = req_tdata[15:0];
   assign req.block_count  = req_tdata[21:16];
   assign req.copy_on_read = req_tdata[22];
   assign req.cache_mode   = req_tdata[24:23];

   cowm_ram #(
      .WIDTH (2),
      .DEPTH (NUM_BLOCKS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cowm_seq #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_take  (desc_take)
   );

   cowm_bytes u_bytes (
      .clock        (clock),
      .reset        (reset),
      .desc         (desc),
      .desc_valid   (desc_valid),
      .desc_take    (desc_take),
      .shift        (eff_shift),
      .device_bytes (device_bytes_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

### tb/cow_overlay_block_state_map_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for cow_overlay_block_state_map_top: random and directed
// requests, an in-bench model of the block map, and field-by-field response checks.
// Depends on cowm_pkg and the block's RTL only.

module cow_overlay_block_state_map_top_test;
   import cowm_pkg::*;

   localparam int MAP_DEPTH = 65536;
   localparam int WINDOW = 64;
   localparam int HOLD_AT = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_MAX = 50;
   localparam longint unsigned BYTES_LIMIT = (64'd1 << BYTES_W) - 1;
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_CODE = 3'd7;

   typedef struct packed {
      action_type         action;
      logic [IDX_W-1:0]   first_block;
      logic [CNT_W-1:0]   run_blocks;
      logic [BYTES_W-1:0] valid_bytes;
      logic [BYTES_W-1:0] tail_bytes;
      logic               copy_to_overlay;
      logic               present;
      logic               trimmed;
      logic               last;
   } run_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_addr = 1'b0;
   logic [DEV_W-1:0]      csr_wdata = '0;

   logic [1:0]            block_map [MAP_DEPTH];
   logic [SHIFT_W-1:0]    cfg_shift;
   logic [DEV_W-1:0]      cfg_device;

   req_type               queued_requests [$];
   run_result_type        awaited_runs [$];
   req_type               req_now;
   run_result_type        wanted_run;
   int                    requests_accepted = 0;
   int                    runs_seen = 0;
   int                    mismatch_count = 0;
   int                    idle_pct = 0;
   int                    req_gap = 0;
   int                    rsp_stall = 0;
   int                    hold_left = 0;
   logic                  hold_done = 1'b0;

   cow_overlay_block_state_map_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned shift_now();
      if (cfg_shift < SHIFT_MIN) return SHIFT_MIN;
      if (cfg_shift > SHIFT_MAX) return SHIFT_MAX;
      return cfg_shift;
   endfunction

   function automatic logic [1:0] state_at(int pos);
      if (pos >= MAP_DEPTH) return BS_FREE;
      return block_map[pos];
   endfunction

   function automatic void mark_block(int pos, logic [1:0] st);
      if (pos < MAP_DEPTH) block_map[pos] = st;
   endfunction

   function automatic void split_bytes(int pos, int run, output longint unsigned valid_b,
                                       output longint unsigned tail_b);
      longint unsigned offs;
      longint unsigned total;
      offs = longint'(pos) << shift_now();
      total = longint'(run) << shift_now();
      valid_b = 0;
      if (offs < cfg_device) begin
         valid_b = cfg_device - offs;
         if (valid_b > total) valid_b = total;
      end
      tail_b = total - valid_b;
   endfunction

   function automatic void queue_result(action_type act, int first, int run,
                                        longint unsigned valid_b, longint unsigned tail_b,
                                        logic copy, logic present, logic trimmed, logic last);
      run_result_type r;
      r.action = act;
      r.first_block = first[IDX_W-1:0];
      r.run_blocks = run[CNT_W-1:0];
      r.valid_bytes = (valid_b > BYTES_LIMIT) ? BYTES_LIMIT[BYTES_W-1:0] : valid_b[BYTES_W-1:0];
      r.tail_bytes = (tail_b > BYTES_LIMIT) ? BYTES_LIMIT[BYTES_W-1:0] : tail_b[BYTES_W-1:0];
      r.copy_to_overlay = copy;
      r.present = present;
      r.trimmed = trimmed;
      r.last = last;
      awaited_runs.push_back(r);
   endfunction

   function automatic void map_request_to_runs(req_type rq);
      int pos;
      int cnt;
      int run;
      int k;
      int idx;
      logic [1:0] st;
      longint unsigned bsize;
      longint unsigned v;
      longint unsigned t;
      bsize = 64'd1 << shift_now();
      idx = rq.block_index;
      st = state_at(idx);
      case (rq.cmd)
         CMD_READ: begin
            cnt = rq.block_count;
            if (cnt == 0) cnt = 1;
            if (cnt > MAX_RUN) cnt = MAX_RUN;
            pos = idx;
            while (cnt > 0) begin
               st = state_at(pos);
               run = 1;
               while (run < cnt && state_at(pos + run) == st) run++;
               if (st == BS_FREE) begin
                  split_bytes(pos, run, v, t);
                  queue_result(ACT_RD_UNDER, pos, run, v, t, rq.copy_on_read, 1'b0, 1'b0,
                               run == cnt);
                  if (rq.copy_on_read) begin
                     for (k = 0; k < run; k++) mark_block(pos + k, BS_ALLOC);
                  end
               end else if (st == BS_ALLOC) begin
                  queue_result(ACT_RD_OVER, pos, run, run * bsize, 0, 1'b0, 1'b0, 1'b0,
                               run == cnt);
               end else begin
                  queue_result(ACT_ZERO, pos, run, run * bsize, 0, 1'b0, 1'b0, 1'b0,
                               run == cnt);
               end
               pos += run;
               cnt -= run;
            end
         end
         CMD_CACHE: begin
            if (st == BS_ALLOC) begin
               queue_result(ACT_ADVISE, idx, 1, bsize, 0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else if (st != BS_FREE || rq.cache_mode == CM_IGNORE) begin
               queue_result(ACT_NONE, idx, 1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
               split_bytes(idx, 1, v, t);
               case (rq.cache_mode)
                  CM_PASS: queue_result(ACT_FWD, idx, 1, v, t, 1'b0, 1'b0, 1'b0, 1'b1);
                  CM_RDONLY: queue_result(ACT_RD_UNDER, idx, 1, v, t, 1'b0, 1'b0, 1'b0, 1'b1);
                  default: begin
                     queue_result(ACT_RD_UNDER, idx, 1, v, t, 1'b1, 1'b0, 1'b0, 1'b1);
                     mark_block(idx, BS_ALLOC);
                  end
               endcase
            end
         end
         CMD_WRITE: begin
            mark_block(idx, BS_ALLOC);
            queue_result(ACT_WRITE, idx, 1, bsize, 0, 1'b0, 1'b0, 1'b0, 1'b1);
         end
         CMD_TRIM: begin
            mark_block(idx, BS_TRIM);
            queue_result(ACT_NONE, idx, 1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
         end
         CMD_STATUS: begin
            queue_result(ACT_NONE, idx, 1, 0, 0, 1'b0, st != BS_FREE, st == BS_TRIM, 1'b1);
         end
         default: begin
            queue_result(ACT_NONE, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_MAX) $display("mismatch at response %0d: %s", runs_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, longint unsigned got, longint unsigned wanted);
      if (got != wanted) report_mismatch($sformatf("%s got %0d want %0d", name, got, wanted));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            map_request_to_runs(req_now);
            requests_accepted <= requests_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (queued_requests.size() != 0) begin
               req_now = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, req_now.cache_mode, req_now.copy_on_read,
                             req_now.block_count, req_now.block_index};
               req_tuser <= req_now.cmd;
               if ($urandom_range(0, 99) < idle_pct) req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started once the pipe has traffic
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && requests_accepted == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_tready <= 1'b0;
         rsp_stall <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_runs.size() == 0) begin
            report_mismatch($sformatf("unexpected response, action %0d block %0d",
                                      rsp_tuser, rsp_tdata[15:0]));
         end else begin
            wanted_run = awaited_runs.pop_front();
            check_field("action", rsp_tuser, wanted_run.action);
            check_field("first_block", rsp_tdata[15:0], wanted_run.first_block);
            check_field("run_blocks", rsp_tdata[21:16], wanted_run.run_blocks);
            check_field("valid_bytes", rsp_tdata[43:22], wanted_run.valid_bytes);
            check_field("tail_bytes", rsp_tdata[65:44], wanted_run.tail_bytes);
            check_field("copy_to_overlay", rsp_tdata[66], wanted_run.copy_to_overlay);
            check_field("present", rsp_tdata[67], wanted_run.present);
            check_field("trimmed", rsp_tdata[68], wanted_run.trimmed);
            check_field("last", rsp_tlast, wanted_run.last);
         end
         runs_seen++;
      end
   end

   task automatic write_register(logic addr, logic [DEV_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      if (addr == CSR_BLOCK_SHIFT) cfg_shift = value[SHIFT_W-1:0];
      else cfg_device = value;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || awaited_runs.size() != 0);
   endtask

   task automatic start_phase(logic [SHIFT_W-1:0] shift, logic [DEV_W-1:0] dev, int idle);
      wait_idle();
      write_register(CSR_BLOCK_SHIFT, {{(DEV_W-SHIFT_W){1'b0}}, shift});
      write_register(CSR_DEVICE_BYTES, dev);
      @(negedge clock);
      idle_pct = idle;
   endtask

   function automatic void add_request(logic [2:0] cmd, int idx, int cnt, logic cor,
                                       logic [1:0] mode);
      req_type r;
      r.cmd = cmd;
      r.block_index = idx[IDX_W-1:0];
      r.block_count = cnt[CNT_W-1:0];
      r.copy_on_read = cor;
      r.cache_mode = mode;
      queued_requests.push_back(r);
   endfunction

   // mostly clustered on a small window so reads meet written and trimmed blocks
   function automatic void queue_random_requests(int n, int base);
      int pick;
      int idx;
      int cnt;
      logic [2:0] cmd;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, MAP_DEPTH - 1);
         else idx = base + $urandom_range(0, WINDOW - 1);
         if ($urandom_range(0, 99) < 85) cnt = $urandom_range(1, MAX_RUN);
         else cnt = $urandom_range(0, (1 << CNT_W) - 1);
         pick = $urandom_range(0, 99);
         if (pick < 35) cmd = CMD_READ;
         else if (pick < 55) cmd = CMD_WRITE;
         else if (pick < 68) cmd = CMD_TRIM;
         else if (pick < 83) cmd = CMD_CACHE;
         else if (pick < 93) cmd = CMD_STATUS;
         else cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
         add_request(cmd, idx, cnt, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end
   endfunction

   initial begin
      int base;
      longint unsigned dev;
      foreach (block_map[i]) block_map[i] = BS_FREE;
      cfg_shift = SHIFT_RESET;
      cfg_device = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 512-byte blocks, device ends 100 bytes into block 5
      start_phase(SHIFT_MIN, 33'd2660, 0);
      add_request(CMD_STATUS, 0, 1, 1'b0, CM_IGNORE);
      add_request(CMD_READ, 0, 8, 1'b0, CM_IGNORE);
      add_request(CMD_WRITE, 2, 1, 1'b0, CM_IGNORE);
      add_request(CMD_TRIM, 3, 1, 1'b0, CM_IGNORE);
      add_request(CMD_WRITE, 4, 1, 1'b0, CM_IGNORE);
      add_request(CMD_STATUS, 2, 1, 1'b0, CM_IGNORE);
      add_request(CMD_STATUS, 3, 1, 1'b0, CM_IGNORE);
      add_request(CMD_READ, 0, 8, 1'b0, CM_IGNORE);
      add_request(CMD_READ, 0, 0, 1'b0, CM_IGNORE);
      add_request(CMD_READ, 5, 63, 1'b1, CM_IGNORE);
      add_request(CMD_READ, 0, 40, 1'b0, CM_IGNORE);
      add_request(CMD_READ, 65520, MAX_RUN, 1'b1, CM_IGNORE);
      add_request(CMD_READ, 65530, MAX_RUN, 1'b0, CM_IGNORE);
      add_request(CMD_TRIM, 65535, 1, 1'b0, CM_IGNORE);
      add_request(CMD_STATUS, 65535, 1, 1'b0, CM_IGNORE);
      add_request(CMD_CACHE, 40, 1, 1'b0, CM_IGNORE);
      add_request(CMD_CACHE, 40, 1, 1'b1, CM_PASS);
      add_request(CMD_CACHE, 40, 1, 1'b0, CM_RDONLY);
      add_request(CMD_CACHE, 40, 1, 1'b0, CM_COPY);
      add_request(CMD_CACHE, 40, 1, 1'b0, CM_PASS);
      add_request(CMD_CACHE, 3, 1, 1'b0, CM_COPY);
      add_request(CMD_CACHE, 1, 1, 1'b1, CM_COPY);
      add_request(CMD_FIRST_UNUSED, 65535, 63, 1'b1, CM_COPY);
      add_request(3'd6, 12345, 7, 1'b0, CM_PASS);
      add_request(CMD_LAST_CODE, 0, 0, 1'b0, CM_IGNORE);

      // below the block size range, empty device
      start_phase(5'd0, '0, 30);
      queue_random_requests(57, $urandom_range(0, 200));

      // above the block size range, 4 GiB device ending near the top of the map
      start_phase(5'd31, 33'h1_0000_0000, 0);
      queue_random_requests(57, 65480);

      base = $urandom_range(0, 65000);
      dev = (longint'(base) << 12) + $urandom_range(0, 1 << 14);
      start_phase(5'd12, dev[DEV_W-1:0], 50);
      queue_random_requests(57, base);

      base = $urandom_range(0, 65535);
      start_phase(5'($urandom_range(0, 31)), {1'($urandom_range(0, 1)), 32'($urandom)}, 20);
      queue_random_requests(57, base);

      start_phase(SHIFT_MIN, {DEV_W{1'b1}}, 35);
      queue_random_requests(57, 65500);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (awaited_runs.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", awaited_runs.size()));
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
